[sv/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge; off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/necd_pkg.sv]
// Shared types, phase codes and timing constants for the NEC IR decoder.
// No dependencies.
package necd_pkg;

  localparam int FRAME_BITS_DEF = 32;
  localparam int DATA_W = 32;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_BITS = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic [7:0] REPEAT_MIN = 8'd30;
  localparam logic [7:0] REPEAT_MAX = 8'd40;

  localparam logic [REG_IDX_W-1:0] R_AGC_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] R_AGC_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] R_GAP_MIN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] R_GAP_MAX   = 3'd3;
  localparam logic [REG_IDX_W-1:0] R_SHORT_MIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] R_SHORT_MAX = 3'd5;
  localparam logic [REG_IDX_W-1:0] R_LONG_MIN  = 3'd6;
  localparam logic [REG_IDX_W-1:0] R_LONG_MAX  = 3'd7;

  localparam logic [7:0] RST_AGC_MIN   = 8'd120;
  localparam logic [7:0] RST_AGC_MAX   = 8'd160;
  localparam logic [7:0] RST_GAP_MIN   = 8'd60;
  localparam logic [7:0] RST_GAP_MAX   = 8'd80;
  localparam logic [7:0] RST_SHORT_MIN = 8'd5;
  localparam logic [7:0] RST_SHORT_MAX = 8'd10;
  localparam logic [7:0] RST_LONG_MIN  = 8'd20;
  localparam logic [7:0] RST_LONG_MAX  = 8'd30;

  typedef struct packed {
    logic [7:0] agc_min;
    logic [7:0] agc_max;
    logic [7:0] gap_min;
    logic [7:0] gap_max;
    logic [7:0] short_min;
    logic [7:0] short_max;
    logic [7:0] long_min;
    logic [7:0] long_max;
  } timing_cfg_t;

  typedef struct packed {
    logic              frame_ready;
    logic [DATA_W-1:0] frame_data;
    logic [1:0]        phase;
  } result_t;

  // Exclusive window test.
  function automatic logic in_win(logic [7:0] t, logic [7:0] lo, logic [7:0] hi);
    return (t > lo) && (t < hi);
  endfunction

endpackage

[sv/necd_core.sv]
// Decoder state and per-edge next-state logic.
// Depends on necd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module necd_core import necd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        mode,
  input  logic        level,
  input  logic [7:0]  ticks,
  input  timing_cfg_t cfg,
  output result_t     result
);

  localparam int CW = $clog2(FRAME_BITS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(FRAME_BITS);

  logic [1:0]        phase, phase_next;
  logic [CW-1:0]     bits_left, bits_left_next;
  logic [DATA_W-1:0] shift_buf, shift_buf_next;
  logic              ready, ready_next;

  logic [CW-1:0] cnt_dec;
  logic [31:0]   cnt_ext;
  logic          win_short, win_long, clear;

  assign cnt_dec   = bits_left - CW'(1);
  assign cnt_ext   = 32'(cnt_dec);
  assign win_short = in_win(ticks, cfg.short_min, cfg.short_max);
  assign win_long  = in_win(ticks, cfg.long_min, cfg.long_max);

  always_comb begin
    phase_next     = phase;
    bits_left_next = bits_left;
    shift_buf_next = shift_buf;
    ready_next     = ready;
    clear          = 1'b0;
    if (mode) begin
      clear      = 1'b1;
      ready_next = 1'b0;
    end else if (!ready) begin
      clear = 1'b1;
      case (phase)
        PH_PRE: begin
          if (level && in_win(ticks, cfg.agc_min, cfg.agc_max)) begin
            phase_next = PH_GAP;
            clear      = 1'b0;
          end
        end
        PH_GAP: begin
          if (!level && in_win(ticks, cfg.gap_min, cfg.gap_max)) begin
            phase_next = PH_BITS;
            clear      = 1'b0;
          end else if (!level && in_win(ticks, REPEAT_MIN, REPEAT_MAX)) begin
            phase_next = PH_FIN;
            clear      = 1'b0;
          end
        end
        PH_BITS: begin
          if (!level && (win_short || win_long)) begin
            clear          = 1'b0;
            bits_left_next = cnt_dec;
            // positions past the buffer top are dropped
            if (cnt_ext < 32'd32)
              shift_buf_next[cnt_ext[4:0]] = !win_short;
            if (cnt_dec == '0)
              phase_next = PH_FIN;
          end
        end
        PH_FIN: begin
          if (level) begin
            ready_next = 1'b1;
            clear      = 1'b0;
          end
        end
        default: clear = 1'b1;
      endcase
    end
    if (clear) begin
      phase_next     = PH_PRE;
      bits_left_next = CNT_FULL;
      shift_buf_next = '0;
    end
  end

  assign result.frame_ready = ready_next;
  assign result.frame_data  = ready_next ? shift_buf_next : '0;
  assign result.phase       = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PRE;
      bits_left <= CNT_FULL;
      shift_buf <= '0;
      ready     <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      bits_left <= bits_left_next;
      shift_buf <= shift_buf_next;
      ready     <= ready_next;
    end
  end

  `ASSERT_CLK(a_ready_in_fin, ready |-> (phase == PH_FIN), "ready outside final phase")
  `ASSERT_CLK(a_bits_nonzero, (phase == PH_BITS) |-> (bits_left != '0), "bit phase with zero count")
  `ASSERT_CLK(a_cnt_range, bits_left <= CNT_FULL, "bit count above frame length")

endmodule

[sv/nec_ir_frame_decoder_top.sv]
// Top level of the NEC IR frame decoder: timing registers and result buffering.
// Depends on necd_pkg, necd_core and assert_macros.svh.
//
// One edge or start request is taken per clock while in_stall is low; each request
// yields exactly one result (ready flag, payload, phase), decided by a single pass
// of window compares and a bit insert between the state registers. A two-entry
// output buffer (result register plus skid) lets requests flow while a result is
// stalled; in_stall rises only when both entries are full. Timing windows are set
// through cfg_we/cfg_addr/cfg_wdata while rst is low; all bounds are exclusive.
`include "assert_macros.svh"

module nec_ir_frame_decoder_top import necd_pkg::*; #(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic                 level,
  input  logic [7:0]           ticks,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 frame_ready,
  output logic [DATA_W-1:0]    frame_data,
  output logic [1:0]           phase
);

  logic [7:0]  regs [NUM_REGS];
  timing_cfg_t cfg;
  result_t     res_new, res_out, res_skid;
  logic        skid_valid, accept, taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[R_AGC_MIN]   <= RST_AGC_MIN;
      regs[R_AGC_MAX]   <= RST_AGC_MAX;
      regs[R_GAP_MIN]   <= RST_GAP_MIN;
      regs[R_GAP_MAX]   <= RST_GAP_MAX;
      regs[R_SHORT_MIN] <= RST_SHORT_MIN;
      regs[R_SHORT_MAX] <= RST_SHORT_MAX;
      regs[R_LONG_MIN]  <= RST_LONG_MIN;
      regs[R_LONG_MAX]  <= RST_LONG_MAX;
    end else if (cfg_we) begin
      regs[cfg_addr] <= cfg_wdata;
    end
  end

  assign cfg.agc_min   = regs[R_AGC_MIN];
  assign cfg.agc_max   = regs[R_AGC_MAX];
  assign cfg.gap_min   = regs[R_GAP_MIN];
  assign cfg.gap_max   = regs[R_GAP_MAX];
  assign cfg.short_min = regs[R_SHORT_MIN];
  assign cfg.short_max = regs[R_SHORT_MAX];
  assign cfg.long_min  = regs[R_LONG_MIN];
  assign cfg.long_max  = regs[R_LONG_MAX];

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign taken    = out_valid && !out_stall;

  necd_core #(
    .FRAME_BITS(FRAME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (mode),
    .level  (level),
    .ticks  (ticks),
    .cfg    (cfg),
    .result (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken) begin
      if (skid_valid) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end else if (accept) begin
        res_out <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (accept) begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end
    end else if (accept) begin
      res_skid   <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign frame_ready = res_out.frame_ready;
  assign frame_data  = res_out.frame_data;
  assign phase       = res_out.phase;

  `ASSERT_CLK(a_skid_behind_out, skid_valid |-> out_valid, "skid full with empty output")
  `ASSERT_CLK(a_skid_drain, (skid_valid && !out_stall) |=> (out_valid && !skid_valid), "skid not drained")
  `ASSERT_CLK(a_data_gated, (out_valid && !frame_ready) |-> (frame_data == '0), "payload shown before ready")

endmodule
